// File: sv/soad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soad_pkg
// shared types, register codes and helper function of the sonar drive block
// ----------------------------------------------------------------------------
package soad_pkg;

    localparam int DIST_W  = 10;
    localparam int DUTY_W  = 8;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 10;

    typedef enum logic [CIDX_W-1:0] {
        REG_WALL_NEAR    = 3'd0,
        REG_WALL_MID     = 3'd1,
        REG_WALL_FAR     = 3'd2,
        REG_SPEED_SLOW   = 3'd3,
        REG_SPEED_MEDIUM = 3'd4,
        REG_SPEED_FAST   = 3'd5,
        REG_DUTY_OFF     = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_FWD   = 2'd0,
        MODE_BACK  = 2'd1,
        MODE_LEFT  = 2'd2,
        MODE_RIGHT = 2'd3
    } t_mode;

    localparam logic [DIST_W-1:0] RST_WALL_NEAR    = 10'd20;
    localparam logic [DIST_W-1:0] RST_WALL_MID     = 10'd40;
    localparam logic [DIST_W-1:0] RST_WALL_FAR     = 10'd60;
    localparam logic [DUTY_W-1:0] RST_SPEED_SLOW   = 8'd40;
    localparam logic [DUTY_W-1:0] RST_SPEED_MEDIUM = 8'd70;
    localparam logic [DUTY_W-1:0] RST_SPEED_FAST   = 8'd100;
    localparam logic [DUTY_W-1:0] RST_DUTY_OFF     = 8'd0;

    typedef struct packed {
        logic [DIST_W-1:0] wall_near;
        logic [DIST_W-1:0] wall_mid;
        logic [DIST_W-1:0] wall_far;
        logic [DUTY_W-1:0] speed_slow;
        logic [DUTY_W-1:0] speed_medium;
        logic [DUTY_W-1:0] speed_fast;
        logic [DUTY_W-1:0] duty_off;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] dist_front;
        logic [DIST_W-1:0] dist_right;
        logic [DIST_W-1:0] dist_left;
        logic [DIST_W-1:0] dist_back;
    } t_item;

    typedef struct packed {
        logic [DUTY_W-1:0] right_u_duty;
        logic [DUTY_W-1:0] right_v_duty;
        logic [DUTY_W-1:0] left_u_duty;
        logic [DUTY_W-1:0] left_v_duty;
        t_mode             drive_mode;
    } t_result;

    // later tests override earlier ones, so the near test wins
    function automatic logic [DUTY_W-1:0] pick_speed(input logic [DIST_W-1:0] d,
                                                     input t_cfg cfg);
        logic [DUTY_W-1:0] s;
        s = cfg.speed_slow;
        if (d >= cfg.wall_far)
            s = cfg.speed_fast;
        if (d >= cfg.wall_mid && d < cfg.wall_far)
            s = cfg.speed_medium;
        if (d < cfg.wall_near)
            s = cfg.speed_slow;
        return s;
    endfunction

endpackage

// File: sv/soad_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soad interfaces
// valid/ready channels for sonar sweeps, drive results and register writes
// ----------------------------------------------------------------------------
interface soad_in_if;
    logic                         valid;
    logic                         ready;
    logic [soad_pkg::DIST_W-1:0]  dist_front;
    logic [soad_pkg::DIST_W-1:0]  dist_right;
    logic [soad_pkg::DIST_W-1:0]  dist_left;
    logic [soad_pkg::DIST_W-1:0]  dist_back;

    modport source (output valid, dist_front, dist_right, dist_left, dist_back,
                    input ready);
    modport sink (input valid, dist_front, dist_right, dist_left, dist_back,
                  output ready);
endinterface

interface soad_out_if;
    logic                         valid;
    logic                         ready;
    logic [soad_pkg::DUTY_W-1:0]  right_u_duty;
    logic [soad_pkg::DUTY_W-1:0]  right_v_duty;
    logic [soad_pkg::DUTY_W-1:0]  left_u_duty;
    logic [soad_pkg::DUTY_W-1:0]  left_v_duty;
    logic [1:0]                   drive_mode;

    modport source (output valid, right_u_duty, right_v_duty, left_u_duty,
                    left_v_duty, drive_mode, input ready);
    modport sink (input valid, right_u_duty, right_v_duty, left_u_duty,
                  left_v_duty, drive_mode, output ready);
endinterface

interface soad_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [soad_pkg::CIDX_W-1:0]  index;
    logic [soad_pkg::CDATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/soad_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soad_cfg_regs
// threshold and duty registers, written through the register channel
// ----------------------------------------------------------------------------
module soad_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [soad_pkg::CIDX_W-1:0]  i_idx,
    input  logic [soad_pkg::CDATA_W-1:0] i_data,
    output soad_pkg::t_cfg               o_cfg
);

    soad_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wall_near    <= soad_pkg::RST_WALL_NEAR;
            r_cfg.wall_mid     <= soad_pkg::RST_WALL_MID;
            r_cfg.wall_far     <= soad_pkg::RST_WALL_FAR;
            r_cfg.speed_slow   <= soad_pkg::RST_SPEED_SLOW;
            r_cfg.speed_medium <= soad_pkg::RST_SPEED_MEDIUM;
            r_cfg.speed_fast   <= soad_pkg::RST_SPEED_FAST;
            r_cfg.duty_off     <= soad_pkg::RST_DUTY_OFF;
        end else if (i_wr) begin
            // unknown indexes are dropped
            unique case (i_idx)
                soad_pkg::REG_WALL_NEAR:    r_cfg.wall_near    <= i_data;
                soad_pkg::REG_WALL_MID:     r_cfg.wall_mid     <= i_data;
                soad_pkg::REG_WALL_FAR:     r_cfg.wall_far     <= i_data;
                soad_pkg::REG_SPEED_SLOW:   r_cfg.speed_slow   <= i_data[soad_pkg::DUTY_W-1:0];
                soad_pkg::REG_SPEED_MEDIUM: r_cfg.speed_medium <= i_data[soad_pkg::DUTY_W-1:0];
                soad_pkg::REG_SPEED_FAST:   r_cfg.speed_fast   <= i_data[soad_pkg::DUTY_W-1:0];
                soad_pkg::REG_DUTY_OFF:     r_cfg.duty_off     <= i_data[soad_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/soad_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soad_step
// one sweep through the avoidance checks and the bridge duty mapping
// ----------------------------------------------------------------------------
module soad_step (
    input  soad_pkg::t_item   i_item,
    input  soad_pkg::t_mode   i_mode,
    input  soad_pkg::t_cfg    i_cfg,
    output soad_pkg::t_result o_res
);

    logic [soad_pkg::DIST_W-1:0] least;
    logic [soad_pkg::DIST_W-1:0] top;
    logic                        both_near;
    logic                        left_wider;
    soad_pkg::t_mode             m;
    logic [soad_pkg::DUTY_W-1:0] p;
    logic [soad_pkg::DUTY_W-1:0] o;

    always_comb begin
        least = i_item.dist_front;
        if (i_item.dist_right < least)
            least = i_item.dist_right;
        if (i_item.dist_left < least)
            least = i_item.dist_left;

        top = i_cfg.wall_near;
        if (i_cfg.wall_mid > top)
            top = i_cfg.wall_mid;
        if (i_cfg.wall_far > top)
            top = i_cfg.wall_far;

        both_near  = (i_item.dist_left < i_cfg.wall_near) &&
                     (i_item.dist_right < i_cfg.wall_near);
        left_wider = i_item.dist_left > i_item.dist_right;

        // checks run in order, each on the mode the previous one left
        m = i_mode;
        if (m == soad_pkg::MODE_FWD && i_item.dist_front < i_cfg.wall_near) begin
            if (both_near)
                m = soad_pkg::MODE_BACK;
            else if (left_wider)
                m = soad_pkg::MODE_LEFT;
            else
                m = soad_pkg::MODE_RIGHT;
        end
        if (m == soad_pkg::MODE_BACK && i_item.dist_back < top)
            m = left_wider ? soad_pkg::MODE_LEFT : soad_pkg::MODE_RIGHT;
        if (m == soad_pkg::MODE_LEFT && !both_near)
            m = soad_pkg::MODE_FWD;
        if (m == soad_pkg::MODE_RIGHT && !both_near)
            m = soad_pkg::MODE_FWD;

        // ending in backward means backing went on, paced by the back sonar
        if (m == soad_pkg::MODE_BACK)
            p = soad_pkg::pick_speed(i_item.dist_back, i_cfg);
        else
            p = soad_pkg::pick_speed(least, i_cfg);
        o = i_cfg.duty_off;

        o_res.drive_mode = m;
        unique case (m)
            soad_pkg::MODE_FWD: begin
                o_res.right_u_duty = p; o_res.right_v_duty = o;
                o_res.left_u_duty  = o; o_res.left_v_duty  = p;
            end
            soad_pkg::MODE_BACK: begin
                o_res.right_u_duty = o; o_res.right_v_duty = p;
                o_res.left_u_duty  = p; o_res.left_v_duty  = o;
            end
            soad_pkg::MODE_LEFT: begin
                o_res.right_u_duty = o; o_res.right_v_duty = p;
                o_res.left_u_duty  = o; o_res.left_v_duty  = p;
            end
            default: begin
                o_res.right_u_duty = p; o_res.right_v_duty = o;
                o_res.left_u_duty  = p; o_res.left_v_duty  = o;
            end
        endcase
    end

endmodule

// File: sv/sonar_obstacle_avoid_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_obstacle_avoid_drive
// an accepted sweep is held in the input register; its result moves to the
// result register when that one is empty or being read
// throughput: one sweep per cycle while results are taken (mode update loop)
// a full result register still takes one more sweep into the input register
// reset: synchronous active low, clears valids, mode to forward, registers
// to their defaults; register writes are always ready
// ----------------------------------------------------------------------------
module sonar_obstacle_avoid_drive (
    input  logic       i_clk,
    input  logic       i_rst_n,
    soad_in_if.sink    i_in,
    soad_out_if.source o_out,
    soad_cfg_if.sink   i_cfg
);

    soad_pkg::t_cfg    cfg;
    soad_pkg::t_result step_res;

    logic              r_in_valid;
    soad_pkg::t_item   r_in;
    logic              r_out_valid;
    soad_pkg::t_result r_out;
    soad_pkg::t_mode   r_mode;
    logic              advance;

    assign i_cfg.ready = 1'b1;

    soad_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    soad_step u_step (
        .i_item (r_in),
        .i_mode (r_mode),
        .i_cfg  (cfg),
        .o_res  (step_res)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= soad_pkg::MODE_FWD;
        end else begin
            if (i_in.valid && i_in.ready)
                r_in_valid <= 1'b1;
            else if (advance)
                r_in_valid <= 1'b0;

            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode      <= step_res.drive_mode;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.dist_front <= i_in.dist_front;
            r_in.dist_right <= i_in.dist_right;
            r_in.dist_left  <= i_in.dist_left;
            r_in.dist_back  <= i_in.dist_back;
        end
        if (advance)
            r_out <= step_res;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.right_u_duty = r_out.right_u_duty;
    assign o_out.right_v_duty = r_out.right_v_duty;
    assign o_out.left_u_duty  = r_out.left_u_duty;
    assign o_out.left_v_duty  = r_out.left_v_duty;
    assign o_out.drive_mode   = r_out.drive_mode;

endmodule

// File: bench/sonar_obstacle_avoid_drive_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_obstacle_avoid_drive_tb
// Sends sonar sweeps and register writes to the drive block. Each accepted
// sweep runs through a local copy of the avoidance machine. The duties and
// the mode it gives are queued and checked, in order, against the results.
// ----------------------------------------------------------------------------
module sonar_obstacle_avoid_drive_tb;

    typedef logic [soad_pkg::DIST_W-1:0]  t_dist;
    typedef logic [soad_pkg::DUTY_W-1:0]  t_duty;
    typedef logic [soad_pkg::CDATA_W-1:0] t_cdata;

    localparam logic [soad_pkg::CIDX_W-1:0] REG_SPARE = 3'd7;   // unmapped index
    localparam int                          HOLD_CYCLES = 60;

    typedef enum int {PH_DIRECTED, PH_RANDOM, PH_PRESSURE, PH_FINAL} t_phase;
    typedef enum int {D_NEAR, D_EDGE, D_ANY, D_EXTREME, D_CLEAR} t_dist_kind;

    logic i_clk = 1'b0;
    logic i_rst_n;

    soad_in_if  sweep_if ();
    soad_out_if drive_if ();
    soad_cfg_if reg_if ();

    sonar_obstacle_avoid_drive dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sweep_if),
        .o_out   (drive_if),
        .i_cfg   (reg_if)
    );

    always #10 i_clk = ~i_clk;

    soad_pkg::t_item   sweep_queue[$];
    soad_pkg::t_result expected_drive[$];
    soad_pkg::t_item   next_sweep;
    soad_pkg::t_cfg    model_cfg;
    soad_pkg::t_mode   model_mode;
    t_phase            phase = PH_DIRECTED;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    bit rx_block     = 1'b0;
    bit sweep_taken  = 1'b0;
    int src_gap      = 0;
    int sink_gap     = 0;
    int n_errors     = 0;
    int n_queued     = 0;
    int n_sweeps     = 0;
    int n_results    = 0;
    int n_settings   = 1;

    // ------------------------------------------------------------------
    // avoidance machine, one sweep
    // ------------------------------------------------------------------
    function automatic t_duty duty_for(input t_dist d, input soad_pkg::t_cfg c);
        // near test has the final word, then the medium band, then far
        if (d < c.wall_near)
            return c.speed_slow;
        else if (d >= c.wall_mid && d < c.wall_far)
            return c.speed_medium;
        else if (d >= c.wall_far)
            return c.speed_fast;
        return c.speed_slow;
    endfunction

    function automatic soad_pkg::t_result bridge_duties(input soad_pkg::t_mode cmd,
                                                        input t_duty p,
                                                        input t_duty o);
        soad_pkg::t_result             r;
        logic [4*soad_pkg::DUTY_W-1:0] d;
        r.drive_mode = cmd;
        case (cmd)
            soad_pkg::MODE_FWD:  d = {p, o, o, p};
            soad_pkg::MODE_BACK: d = {o, p, p, o};
            soad_pkg::MODE_LEFT: d = {o, p, o, p};
            default:             d = {p, o, p, o};
        endcase
        {r.right_u_duty, r.right_v_duty, r.left_u_duty, r.left_v_duty} = d;
        return r;
    endfunction

    function automatic soad_pkg::t_result predict_drive(input soad_pkg::t_item s,
                                                        input soad_pkg::t_cfg c,
                                                        input soad_pkg::t_mode cur);
        soad_pkg::t_result r;
        soad_pkg::t_mode   m;
        t_dist             least;
        t_dist             top;
        t_duty             p;
        bit                both_close;
        m = cur;
        r = '0;
        least = s.dist_front;
        if (s.dist_right < least) least = s.dist_right;
        if (s.dist_left < least) least = s.dist_left;
        p = duty_for(least, c);
        top = c.wall_near;
        if (c.wall_mid > top) top = c.wall_mid;
        if (c.wall_far > top) top = c.wall_far;
        both_close = (s.dist_left < c.wall_near) && (s.dist_right < c.wall_near);

        // checks run in sequence, each on the mode left by the previous one
        if (m == soad_pkg::MODE_FWD) begin
            if (s.dist_front < c.wall_near) begin
                if (both_close)
                    m = soad_pkg::MODE_BACK;
                else
                    m = (s.dist_left > s.dist_right) ? soad_pkg::MODE_LEFT :
                                                       soad_pkg::MODE_RIGHT;
            end
            r = bridge_duties(m, p, c.duty_off);
        end
        if (m == soad_pkg::MODE_BACK) begin
            if (s.dist_back < top) begin
                m = (s.dist_left > s.dist_right) ? soad_pkg::MODE_LEFT :
                                                   soad_pkg::MODE_RIGHT;
                r = bridge_duties(m, p, c.duty_off);
            end else begin
                r = bridge_duties(soad_pkg::MODE_BACK, duty_for(s.dist_back, c),
                                  c.duty_off);
            end
        end
        if (m == soad_pkg::MODE_LEFT || m == soad_pkg::MODE_RIGHT) begin
            if (!both_close)
                m = soad_pkg::MODE_FWD;
            r = bridge_duties(m, p, c.duty_off);
        end
        r.drive_mode = m;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [9:0] want,
                               input logic [9:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: register writes, sweep requests and drive results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        soad_pkg::t_result want;
        if (!i_rst_n) begin
            model_cfg  = '{soad_pkg::RST_WALL_NEAR, soad_pkg::RST_WALL_MID,
                           soad_pkg::RST_WALL_FAR, soad_pkg::RST_SPEED_SLOW,
                           soad_pkg::RST_SPEED_MEDIUM, soad_pkg::RST_SPEED_FAST,
                           soad_pkg::RST_DUTY_OFF};
            model_mode = soad_pkg::MODE_FWD;
            sweep_taken = 1'b0;
        end else begin
            if (reg_if.valid && reg_if.ready) begin
                case (reg_if.index)
                    soad_pkg::REG_WALL_NEAR:    model_cfg.wall_near    = reg_if.data;
                    soad_pkg::REG_WALL_MID:     model_cfg.wall_mid     = reg_if.data;
                    soad_pkg::REG_WALL_FAR:     model_cfg.wall_far     = reg_if.data;
                    soad_pkg::REG_SPEED_SLOW:
                        model_cfg.speed_slow   = reg_if.data[soad_pkg::DUTY_W-1:0];
                    soad_pkg::REG_SPEED_MEDIUM:
                        model_cfg.speed_medium = reg_if.data[soad_pkg::DUTY_W-1:0];
                    soad_pkg::REG_SPEED_FAST:
                        model_cfg.speed_fast   = reg_if.data[soad_pkg::DUTY_W-1:0];
                    soad_pkg::REG_DUTY_OFF:
                        model_cfg.duty_off     = reg_if.data[soad_pkg::DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (drive_if.valid && drive_if.ready) begin
                n_results++;
                if (expected_drive.size() == 0) begin
                    $error("drive result with no sweep outstanding");
                    n_errors++;
                end else begin
                    want = expected_drive.pop_front();
                    check_field("right_u_duty", 10'(want.right_u_duty),
                                10'(drive_if.right_u_duty));
                    check_field("right_v_duty", 10'(want.right_v_duty),
                                10'(drive_if.right_v_duty));
                    check_field("left_u_duty", 10'(want.left_u_duty),
                                10'(drive_if.left_u_duty));
                    check_field("left_v_duty", 10'(want.left_v_duty),
                                10'(drive_if.left_v_duty));
                    check_field("drive_mode", 10'(want.drive_mode),
                                10'(drive_if.drive_mode));
                end
            end
            sweep_taken = sweep_if.valid && sweep_if.ready;
            if (sweep_taken) begin
                n_sweeps++;
                want = predict_drive({sweep_if.dist_front, sweep_if.dist_right,
                                      sweep_if.dist_left, sweep_if.dist_back},
                                     model_cfg, model_mode);
                model_mode = want.drive_mode;
                expected_drive.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------
    // sweep driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sweep_if.valid <= 1'b0;
        end else if (!sweep_if.valid || sweep_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                sweep_if.valid <= 1'b0;
            end else if (sweep_queue.size() > 0) begin
                next_sweep = sweep_queue.pop_front();
                sweep_if.valid      <= 1'b1;
                sweep_if.dist_front <= next_sweep.dist_front;
                sweep_if.dist_right <= next_sweep.dist_right;
                sweep_if.dist_left  <= next_sweep.dist_left;
                sweep_if.dist_back  <= next_sweep.dist_back;
                if (src_idle_en && $urandom_range(0, 4) == 0)
                    src_gap = $urandom_range(1, 10);
            end else begin
                sweep_if.valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (rx_block) begin
            drive_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            drive_if.ready <= 1'b0;
        end else begin
            drive_if.ready <= 1'b1;
            if (sink_idle_en && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 10);
        end
    end

    // long receiver hold while sweeps keep coming, so the block backs up
    initial begin
        wait (phase == PH_PRESSURE);
        @(posedge i_clk);
        rx_block = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_block = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_sweep(input t_dist f, input t_dist r, input t_dist l,
                               input t_dist b);
        soad_pkg::t_item s;
        s.dist_front = f;
        s.dist_right = r;
        s.dist_left  = l;
        s.dist_back  = b;
        sweep_queue.push_back(s);
        n_queued++;
    endtask

    function automatic t_dist top_wall();
        t_dist t;
        t = model_cfg.wall_near;
        if (model_cfg.wall_mid > t) t = model_cfg.wall_mid;
        if (model_cfg.wall_far > t) t = model_cfg.wall_far;
        return t;
    endfunction

    function automatic t_dist dist_of(input t_dist_kind k);
        t_dist base;
        case (k)
            D_NEAR:
                return (model_cfg.wall_near == 0) ? '0 :
                       t_dist'($urandom_range(0, model_cfg.wall_near - 1));
            D_EDGE: begin
                case ($urandom_range(0, 2))
                    0:       base = model_cfg.wall_near;
                    1:       base = model_cfg.wall_mid;
                    default: base = model_cfg.wall_far;
                endcase
                return base - t_dist'($urandom_range(0, 1));
            end
            D_EXTREME:
                return $urandom_range(0, 1) ? '1 : '0;
            D_CLEAR:
                return t_dist'($urandom_range(top_wall(), 1023));
            default:
                return t_dist'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic t_dist any_dist();
        return dist_of(t_dist_kind'($urandom_range(0, 4)));
    endfunction

    // blocked -> backing -> turning -> open road, with random content
    task automatic queue_episode();
        t_dist t;
        t = top_wall();
        repeat ($urandom_range(0, 3))
            queue_sweep(any_dist(), any_dist(), any_dist(), any_dist());
        queue_sweep(dist_of(D_NEAR), dist_of(D_NEAR), dist_of(D_NEAR), any_dist());
        repeat ($urandom_range(0, 3))
            queue_sweep(any_dist(), any_dist(), any_dist(), dist_of(D_CLEAR));
        queue_sweep(any_dist(),
                    $urandom_range(0, 1) ? dist_of(D_NEAR) : any_dist(),
                    $urandom_range(0, 1) ? dist_of(D_NEAR) : any_dist(),
                    (t == 0) ? '0 : t_dist'($urandom_range(0, t - 1)));
        repeat ($urandom_range(0, 2))
            queue_sweep(any_dist(), dist_of(D_NEAR), dist_of(D_NEAR), any_dist());
        queue_sweep(any_dist(), any_dist(), any_dist(), any_dist());
    endtask

    task automatic queue_random(input int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at) begin
            if ($urandom_range(0, 3) == 0)
                queue_sweep(any_dist(), any_dist(), any_dist(), any_dist());
            else
                queue_episode();
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (sweep_queue.size() != 0 || sweep_if.valid);
        while (expected_drive.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [soad_pkg::CIDX_W-1:0] idx, input t_cdata val);
        @(negedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        do @(posedge i_clk); while (!(reg_if.valid && reg_if.ready));
    endtask

    task automatic write_setting(input t_cdata near, input t_cdata mid,
                                 input t_cdata far, input t_cdata slow,
                                 input t_cdata med, input t_cdata fast,
                                 input t_cdata off);
        write_reg(soad_pkg::REG_WALL_NEAR, near);
        write_reg(soad_pkg::REG_WALL_MID, mid);
        write_reg(soad_pkg::REG_WALL_FAR, far);
        write_reg(soad_pkg::REG_SPEED_SLOW, slow);
        write_reg(soad_pkg::REG_SPEED_MEDIUM, med);
        write_reg(soad_pkg::REG_SPEED_FAST, fast);
        write_reg(soad_pkg::REG_DUTY_OFF, off);
        @(negedge i_clk);
        reg_if.valid <= 1'b0;
        n_settings++;
    endtask

    initial begin : stimulus
        int near;
        int mid;
        reg_if.valid        = 1'b0;
        reg_if.index        = '0;
        reg_if.data         = '0;
        i_rst_n             = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed sweeps at reset thresholds 20/40/60
        queue_sweep(100, 100, 100, 0);      // fast forward
        queue_sweep(0, 1023, 1023, 0);      // front blocked, sides equal
        queue_sweep(5, 30, 500, 0);         // front blocked, left wider
        queue_sweep(30, 30, 30, 0);         // gap between near and mid
        queue_sweep(1023, 19, 1023, 1023);
        queue_sweep(20, 1023, 1023, 1023);
        queue_sweep(39, 1023, 1023, 1023);
        queue_sweep(40, 1023, 1023, 1023);
        queue_sweep(1023, 1023, 59, 1023);
        queue_sweep(60, 1023, 1023, 0);
        queue_sweep(10, 10, 10, 1023);      // all close: back at far speed
        queue_sweep(10, 10, 10, 60);        // back distance at the top wall
        queue_sweep(900, 3, 5, 50);         // back stops, turn left and hold
        queue_sweep(0, 5, 5, 0);            // still boxed in
        queue_sweep(0, 5, 500, 0);          // left opens up
        queue_sweep(0, 0, 0, 0);            // back, turn right, all in one sweep
        queue_sweep(1023, 0, 0, 1023);
        queue_sweep(0, 19, 10, 0);
        queue_sweep(0, 20, 0, 0);           // right opens up
        queue_sweep(1023, 1023, 1023, 1023);
        queue_sweep(0, 0, 0, 1023);
        queue_sweep(0, 1023, 0, 59);
        wait_idle();

        phase = PH_RANDOM;
        queue_random(200);
        wait_idle();
        queue_random(200);
        wait_idle();

        // every threshold at the top, speed data with bits above the duty width
        write_setting(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h000, 10'h280, 10'h0FF);
        @(negedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= REG_SPARE;
        reg_if.data  <= 10'h155;
        do @(posedge i_clk); while (!reg_if.ready);
        @(negedge i_clk);
        reg_if.valid <= 1'b0;
        queue_random(250);
        wait_idle();

        write_setting(0, 0, 0, 0, 255, 255, 0);
        queue_random(250);
        wait_idle();

        // unordered thresholds
        write_setting(t_cdata'($urandom_range(300, 700)), t_cdata'($urandom_range(0, 299)),
                      t_cdata'($urandom_range(100, 500)), t_cdata'($urandom_range(0, 255)),
                      t_cdata'($urandom_range(0, 255)), t_cdata'($urandom_range(0, 255)),
                      t_cdata'($urandom_range(0, 255)));
        queue_random(250);
        wait_idle();

        near = $urandom_range(1, 300);
        mid  = near + $urandom_range(0, 300);
        write_setting(t_cdata'(near), t_cdata'(mid), t_cdata'(mid + $urandom_range(0, 300)),
                      t_cdata'($urandom_range(0, 255)), t_cdata'($urandom_range(0, 255)),
                      t_cdata'($urandom_range(0, 255)), t_cdata'($urandom_range(0, 255)));
        queue_random(250);
        wait_idle();

        phase = PH_PRESSURE;
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        queue_random(150);
        wait_idle();

        write_setting(t_cdata'(soad_pkg::RST_WALL_NEAR), t_cdata'(soad_pkg::RST_WALL_MID),
                      t_cdata'(soad_pkg::RST_WALL_FAR), t_cdata'(soad_pkg::RST_SPEED_SLOW),
                      t_cdata'(soad_pkg::RST_SPEED_MEDIUM), t_cdata'(soad_pkg::RST_SPEED_FAST),
                      t_cdata'(soad_pkg::RST_DUTY_OFF));
        phase = PH_FINAL;
        queue_random(150);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (expected_drive.size() != 0) begin
            $error("%0d drive results never arrived", expected_drive.size());
            n_errors++;
        end
        $display("run covered %0d sweeps and %0d drive results over %0d threshold/duty settings,",
                 n_sweeps, n_results, n_settings);
        $display("including extreme and unordered thresholds and a stalled receiver");
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
